@@ src/gdd_pkg.sv @@
// ----------------------------------------------------------------------------
// gdd_pkg
// Shared types, constants and calendar helpers for the date difference core.
// ----------------------------------------------------------------------------
package gdd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 6;
  localparam int CDAY_W  = 5;
  localparam int DOY_W   = 9;
  localparam int DIFF_W  = 23;
  localparam int WY_W    = 15;
  localparam int TOTAL_W = 24;   // day number of a date, unsigned
  localparam int PROD_W  = 28;   // shared multiplier result
  localparam int MULB_W  = 14;   // shared multiplier constant operand
  localparam int Q100_W  = 8;    // year / 100 for years below 16384
  localparam int IN_W    = 48;
  localparam int OUT_W   = 72;

  // Reciprocal of 100 scaled by 2^20, exact for operands below 2^14
  localparam logic [MULB_W-1:0] RECIP_100  = 14'd10486;
  localparam int                RECIP_SH   = 20;
  localparam logic [MULB_W-1:0] DAYS_YEAR  = 14'd365;

  localparam logic [DOY_W-1:0] LEN_LEAP   = 9'd366;
  localparam logic [DOY_W-1:0] LEN_COMMON = 9'd365;

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  // One queued item: years clamped, months cleaned, raw days
  typedef struct packed {
    logic [YEAR_W-1:0]  y1;
    logic [MONTH_W-1:0] m1;
    logic [DAY_W-1:0]   d1;
    logic [YEAR_W-1:0]  y2;
    logic [MONTH_W-1:0] m2;
    logic [DAY_W-1:0]   d2;
  } item_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic valid;
  } queue_stat_t;

  // Month length in a common year
  function automatic logic [CDAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [CDAY_W-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     r = 5'd30;
      4'd2:                                        r = 5'd28;
      default:                                     r = 5'd0;
    endcase
    return r;
  endfunction

  // Days before the first of a month in a common year
  function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ src/gregorian_date_difference_core.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_difference_core
// Days between two Gregorian dates, with ordinal day and year-span results.
//
//   channel  dir  data bits  content
//   s_*      in   48         two dates: year, month, day each
//   m_*      out  72         difference, whole years, ordinal, days left, date
//
// An item passes from queue head to output register in three multiplier
// steps and one finishing step per date through the one shared
// multiplier, plus load and output. A two-entry queue keeps input accepted,
// until it fills, while the back end works or the output stalls. Reset (rst,
// synchronous) empties the queue and the output; a stalled output holds the back end.
// ----------------------------------------------------------------------------
module gregorian_date_difference_core #(
  parameter int YEAR_LIMIT = 9999
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // first_year, first_month, first_day, second_year, second_month, second_day
  input  logic [gdd_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // day_difference, whole_years, day_of_year, days_left, clean_month,
  // clean_day, zero fill
  output logic [gdd_pkg::OUT_W-1:0] m_tdata
);

  gdd_pkg::queue_stat_t stat;
  gdd_pkg::item_t       entry;
  gdd_pkg::item_t       head;
  logic                 push;
  logic                 pop;

  gdd_front #(
    .YEAR_LIMIT(YEAR_LIMIT)
  ) u_front (
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .stat    (stat),
    .push    (push),
    .entry   (entry)
  );

  gdd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .entry(entry),
    .pop  (pop),
    .stat (stat),
    .head (head)
  );

  gdd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .stat    (stat),
    .head    (head),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

endmodule

@@ src/gdd_front.sv @@
// ----------------------------------------------------------------------------
// gdd_front
// Input side: unpacks a transaction, clamps the years and cleans the months,
// and pushes the item into the queue.
// ----------------------------------------------------------------------------
module gdd_front #(
  parameter int YEAR_LIMIT = 9999
) (
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [gdd_pkg::IN_W-1:0] s_tdata,
  input  gdd_pkg::queue_stat_t     stat,
  output logic                     push,
  output gdd_pkg::item_t           entry
);

  logic [gdd_pkg::YEAR_W-1:0]  raw_y1, raw_y2;
  logic [gdd_pkg::MONTH_W-1:0] raw_m1, raw_m2;

  function automatic logic [gdd_pkg::YEAR_W-1:0] clamp_year(
    input logic [gdd_pkg::YEAR_W-1:0] y);
    logic [gdd_pkg::YEAR_W-1:0] r;
    if (y == '0) begin
      r = gdd_pkg::YEAR_W'(1);
    end else if (int'(y) > YEAR_LIMIT) begin
      r = gdd_pkg::YEAR_W'(YEAR_LIMIT);
    end else begin
      r = y;
    end
    return r;
  endfunction

  function automatic logic [gdd_pkg::MONTH_W-1:0] clean_month(
    input logic [gdd_pkg::MONTH_W-1:0] m);
    logic [gdd_pkg::MONTH_W-1:0] r;
    if (m >= gdd_pkg::MON_JAN && m <= gdd_pkg::MON_DEC) begin
      r = m;
    end else begin
      r = gdd_pkg::MON_JAN;
    end
    return r;
  endfunction

  // Field unpack
  assign raw_y1 = s_tdata[13:0];
  assign raw_m1 = s_tdata[17:14];
  assign raw_y2 = s_tdata[37:24];
  assign raw_m2 = s_tdata[41:38];

  // Classification of the item
  always_comb begin
    entry.y1 = clamp_year(raw_y1);
    entry.m1 = clean_month(raw_m1);
    entry.d1 = s_tdata[23:18];
    entry.y2 = clamp_year(raw_y2);
    entry.m2 = clean_month(raw_m2);
    entry.d2 = s_tdata[47:42];
  end

  assign s_tready = !stat.full;
  assign push     = s_tvalid && !stat.full;

endmodule

@@ src/gdd_queue.sv @@
// ----------------------------------------------------------------------------
// gdd_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module gdd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  gdd_pkg::item_t       entry,
  input  logic                 pop,
  output gdd_pkg::queue_stat_t stat,
  output gdd_pkg::item_t       head
);

  gdd_pkg::item_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign head       = mem[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.valid = (count != 2'd0);

endmodule

@@ src/gdd_back.sv @@
// ----------------------------------------------------------------------------
// gdd_back
// Execution side: a step sequencer around one shared multiplier that turns
// each date into a day number, then forms the results in an output register.
// ----------------------------------------------------------------------------
module gdd_back (
  input  logic                      clk,
  input  logic                      rst,
  input  gdd_pkg::queue_stat_t      stat,
  input  gdd_pkg::item_t            head,
  output logic                      pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [gdd_pkg::OUT_W-1:0] m_tdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_QY   = 3'd1;  // y * (2^20 / 100)
  localparam logic [2:0] ST_QP   = 3'd2;  // (y - 1) * (2^20 / 100)
  localparam logic [2:0] ST_P365 = 3'd3;  // (y - 1) * 365
  localparam logic [2:0] ST_DATE = 3'd4;  // finish one date
  localparam logic [2:0] ST_OUT  = 3'd5;  // load the output register

  logic [2:0]                   state;
  logic                         sel;
  gdd_pkg::item_t               cur;
  logic [gdd_pkg::PROD_W-1:0]   prod;
  logic [gdd_pkg::Q100_W-1:0]   qy, qp;
  logic [gdd_pkg::TOTAL_W-1:0]  total1, total2;
  logic [gdd_pkg::DOY_W-1:0]    doy1;
  logic [gdd_pkg::CDAY_W-1:0]   cday1;
  logic                         leap1;
  logic [gdd_pkg::DOY_W-1:0]    doy_cur;
  logic [gdd_pkg::CDAY_W-1:0]   cday_cur;
  logic                         leap_cur;

  logic [gdd_pkg::YEAR_W-1:0]   y, p;
  logic [gdd_pkg::MONTH_W-1:0]  m;
  logic [gdd_pkg::DAY_W-1:0]    d;
  logic [gdd_pkg::MULB_W-1:0]   mul_b;
  logic [gdd_pkg::YEAR_W-1:0]   mul_a;
  logic [gdd_pkg::YEAR_W-1:0]   qy100;
  logic                         is100, leap;
  logic [gdd_pkg::CDAY_W-1:0]   lim, cday;
  logic [gdd_pkg::DOY_W-1:0]    doy;
  logic [gdd_pkg::TOTAL_W-1:0]  total;
  logic                         out_free;
  logic [gdd_pkg::TOTAL_W-1:0]  diff_full;
  logic [gdd_pkg::WY_W-1:0]     whole_years;
  logic [gdd_pkg::DOY_W-1:0]    ylen;

  // Date under work
  assign y = sel ? cur.y2 : cur.y1;
  assign m = sel ? cur.m2 : cur.m1;
  assign d = sel ? cur.d2 : cur.d1;
  assign p = y - gdd_pkg::YEAR_W'(1);

  // Shared multiplier operands
  always_comb begin
    case (state)
      ST_QY: begin
        mul_a = y;
        mul_b = gdd_pkg::RECIP_100;
      end
      ST_QP: begin
        mul_a = p;
        mul_b = gdd_pkg::RECIP_100;
      end
      default: begin
        mul_a = p;
        mul_b = gdd_pkg::DAYS_YEAR;
      end
    endcase
  end

  // Leap test, cleaned day, ordinal day and day number of the date
  // (the ordinal day is registered in ST_P365, before the final sum in ST_DATE)
  always_comb begin
    qy100 = gdd_pkg::YEAR_W'({qy, 6'd0}) + gdd_pkg::YEAR_W'({qy, 5'd0})
          + gdd_pkg::YEAR_W'({qy, 2'd0});
    is100 = (qy100 == y);
    leap  = ((y[1:0] == 2'd0) && !is100) || (is100 && (qy[1:0] == 2'd0));
    lim   = gdd_pkg::month_len(m)
          + gdd_pkg::CDAY_W'((m == gdd_pkg::MON_FEB) && leap);
    if (d == '0 || d > gdd_pkg::DAY_W'(lim)) begin
      cday = gdd_pkg::CDAY_W'(1);
    end else begin
      cday = d[gdd_pkg::CDAY_W-1:0];
    end
    doy   = gdd_pkg::days_before_month(m) + gdd_pkg::DOY_W'(cday)
          + gdd_pkg::DOY_W'((m > gdd_pkg::MON_FEB) && leap);
    total = prod[gdd_pkg::TOTAL_W-1:0]
          + gdd_pkg::TOTAL_W'(p[gdd_pkg::YEAR_W-1:2])
          - gdd_pkg::TOTAL_W'(qp)
          + gdd_pkg::TOTAL_W'(qp[gdd_pkg::Q100_W-1:2])
          + gdd_pkg::TOTAL_W'(doy_cur);
  end

  assign out_free = !m_tvalid || m_tready;
  assign pop      = (state == ST_IDLE) && stat.valid;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (stat.valid) begin
            state <= ST_QY;
            sel   <= 1'b0;
          end
        end
        ST_QY:   state <= ST_QP;
        ST_QP:   state <= ST_P365;
        ST_P365: state <= ST_DATE;
        ST_DATE: begin
          if (sel) begin
            state <= ST_OUT;
          end else begin
            sel   <= 1'b1;
            state <= ST_QY;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    prod <= gdd_pkg::PROD_W'(mul_a) * gdd_pkg::PROD_W'(mul_b);
    if (state == ST_QP) begin
      qy <= prod[gdd_pkg::RECIP_SH +: gdd_pkg::Q100_W];
    end
    if (state == ST_P365) begin
      qp       <= prod[gdd_pkg::RECIP_SH +: gdd_pkg::Q100_W];
      doy_cur  <= doy;
      cday_cur <= cday;
      leap_cur <= leap;
    end
    if (state == ST_DATE) begin
      if (sel) begin
        total2 <= total;
      end else begin
        total1 <= total;
        doy1   <= doy_cur;
        cday1  <= cday_cur;
        leap1  <= leap_cur;
      end
    end
  end

  // Result fields
  assign diff_full   = total2 - total1;
  assign whole_years = gdd_pkg::WY_W'({1'b0, cur.y2}) - gdd_pkg::WY_W'({1'b0, cur.y1})
                     - gdd_pkg::WY_W'(1);
  assign ylen        = leap1 ? gdd_pkg::LEN_LEAP : gdd_pkg::LEN_COMMON;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_tdata <= {7'd0, cday1, cur.m1, ylen - doy1, doy1, whole_years,
                  diff_full[gdd_pkg::DIFF_W-1:0]};
    end
  end

endmodule
